/* hdl/plcrf_pkg.sv */
// ---------------------------------------------------------------------------
// plcrf_pkg
// Types and constants shared by the 1E-frame request framer.
// ---------------------------------------------------------------------------
package plcrf_pkg;

  // Number of bytes in a request header
  localparam int unsigned HDR_LEN = 12;

  // Command codes
  localparam logic [7:0] CMD_BIT_READ   = 8'h00;
  localparam logic [7:0] CMD_WORD_READ  = 8'h01;
  localparam logic [7:0] CMD_BIT_WRITE  = 8'h02;
  localparam logic [7:0] CMD_WORD_WRITE = 8'h03;

  // Item kinds on the request channel
  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_DATA   = 1'b1;

  // Device kinds; the unknown kind sends zero code bytes as a word device
  typedef enum logic [2:0] {
    DEV_X       = 3'd0,
    DEV_Y       = 3'd1,
    DEV_M       = 3'd2,
    DEV_S       = 3'd3,
    DEV_D       = 3'd4,
    DEV_T       = 3'd5,
    DEV_C       = 3'd6,
    DEV_UNKNOWN = 3'd7
  } dev_kind_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_STATION = 1'b0,
    CFG_TIMER   = 1'b1
  } cfg_reg_e;

  localparam logic [7:0] STATION_RESET = 8'hff;
  localparam logic [15:0] TIMER_RESET  = 16'h000a;

  // Input item
  typedef struct packed {
    logic        func;
    logic        write_request;
    logic [2:0]  device_kind;
    logic [31:0] head_address;
    logic [7:0]  point_count;
    logic [15:0] data_value;
  } req_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_item_t;

  // First device code byte
  function automatic logic [7:0] dev_code_lo(input logic [2:0] kind);
    logic [7:0] code;
    case (kind)
      DEV_X, DEV_Y, DEV_M, DEV_S, DEV_D: code = 8'h20;
      DEV_T, DEV_C:                      code = 8'h4e;  // 'N'
      default:                           code = 8'h00;
    endcase
    return code;
  endfunction

  // Second device code byte
  function automatic logic [7:0] dev_code_hi(input logic [2:0] kind);
    logic [7:0] code;
    case (kind)
      DEV_X:   code = 8'h58;  // 'X'
      DEV_Y:   code = 8'h59;  // 'Y'
      DEV_M:   code = 8'h4d;  // 'M'
      DEV_S:   code = 8'h53;  // 'S'
      DEV_D:   code = 8'h44;  // 'D'
      DEV_T:   code = 8'h54;  // 'T'
      DEV_C:   code = 8'h43;  // 'C'
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* hdl/plc_1e_request_framer.sv */
// ---------------------------------------------------------------------------
// plc_1e_request_framer
// Builds binary 1E-frame PLC read/write requests as a byte stream.
// ---------------------------------------------------------------------------
// The block sends one frame byte per cycle on its output channel while frm_stall
// is low. A header transaction yields 12 bytes; a word data transaction yields
// 2 bytes; a bit data transaction yields one byte or, when it opens a byte that
// is not the last, none. Each accepted transaction is decoded combinationally
// and loaded straight into a 12-byte output shift buffer, and the next
// transaction is taken in the same cycle that the previous buffer's final byte
// is consumed, so the rate is set by the single byte-wide output port. The
// station number and monitor timer are to be written through the configuration
// channel while the block is idle; the user is bound by this, and the block
// itself does not enforce it. cfg_ready is always high.
// ---------------------------------------------------------------------------
module plc_1e_request_framer (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    req_valid,
  output logic                    req_stall,
  input  plcrf_pkg::req_item_t    req,
  // frame byte channel
  output logic                    frm_valid,
  input  logic                    frm_stall,
  output plcrf_pkg::frame_item_t  frm,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [0:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  import plcrf_pkg::*;

  localparam int unsigned CNT_W = $clog2(HDR_LEN + 1);

  // configuration registers
  logic [7:0]  station_number;
  logic [15:0] monitor_timer;

  // frame state
  logic       writing_frame, writing_frame_next;
  logic       word_device, word_device_next;
  logic [7:0] points_left, points_left_next;
  logic [3:0] held_nibble, held_nibble_next;
  logic       nibble_held, nibble_held_next;

  // output shift buffer
  logic [7:0]       byte_buf [HDR_LEN];
  logic [CNT_W-1:0] remaining;
  logic             batch_last;

  // load values
  logic [7:0]       load_bytes [HDR_LEN];
  logic [CNT_W-1:0] load_count;
  logic             load_last;

  logic req_fire, frm_fire;
  logic is_word, ends, done;
  logic [7:0] cnt_dec;

  // handshakes
  assign frm_valid = (remaining != '0);
  assign frm_fire  = frm_valid && !frm_stall;
  assign req_stall = !((remaining == '0) ||
                       ((remaining == CNT_W'(1)) && !frm_stall));
  assign req_fire  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;

  assign frm.frame_byte = byte_buf[0];
  assign frm.last_byte  = batch_last && (remaining == CNT_W'(1));

  // decode one transaction into bytes and next state
  always_comb begin
    is_word = (req.device_kind >= DEV_D);
    ends    = !req.write_request || (req.point_count == 8'd0);
    cnt_dec = points_left - 8'd1;
    done    = (cnt_dec == 8'd0);

    for (int i = 0; i < HDR_LEN; i++) begin
      load_bytes[i] = 8'h00;
    end
    load_count = '0;
    load_last  = 1'b0;

    writing_frame_next = writing_frame;
    word_device_next   = word_device;
    points_left_next   = points_left;
    held_nibble_next   = held_nibble;
    nibble_held_next   = nibble_held;

    if (req.func == FUNC_HEADER) begin
      // build the 12-byte header
      case ({req.write_request, is_word})
        2'b00:   load_bytes[0] = CMD_BIT_READ;
        2'b01:   load_bytes[0] = CMD_WORD_READ;
        2'b10:   load_bytes[0] = CMD_BIT_WRITE;
        default: load_bytes[0] = CMD_WORD_WRITE;
      endcase
      load_bytes[1]  = station_number;
      load_bytes[2]  = monitor_timer[7:0];
      load_bytes[3]  = monitor_timer[15:8];
      load_bytes[4]  = req.head_address[7:0];
      load_bytes[5]  = req.head_address[15:8];
      load_bytes[6]  = req.head_address[23:16];
      load_bytes[7]  = req.head_address[31:24];
      load_bytes[8]  = dev_code_lo(req.device_kind);
      load_bytes[9]  = dev_code_hi(req.device_kind);
      load_bytes[10] = req.point_count;
      load_bytes[11] = 8'h00;
      load_count     = CNT_W'(HDR_LEN);
      load_last      = ends;

      writing_frame_next = !ends;
      word_device_next   = is_word;
      points_left_next   = ends ? 8'd0 : req.point_count;
      held_nibble_next   = 4'd0;
      nibble_held_next   = 1'b0;
    end else if (writing_frame && (points_left != 8'd0)) begin
      points_left_next = cnt_dec;
      load_last        = done;
      if (word_device) begin
        // low byte, then high byte
        load_bytes[0] = req.data_value[7:0];
        load_bytes[1] = req.data_value[15:8];
        load_count    = CNT_W'(2);
      end else if (nibble_held) begin
        // complete a byte, high nibble first
        load_bytes[0]    = {held_nibble, req.data_value[3:0]};
        load_count       = CNT_W'(1);
        held_nibble_next = 4'd0;
        nibble_held_next = 1'b0;
      end else if (done) begin
        // odd last point: pad low nibble
        load_bytes[0] = {req.data_value[3:0], 4'h0};
        load_count    = CNT_W'(1);
      end else begin
        // hold the nibble for the next point
        held_nibble_next = req.data_value[3:0];
        nibble_held_next = 1'b1;
      end
      if (done) begin
        writing_frame_next = 1'b0;
        held_nibble_next   = 4'd0;
        nibble_held_next   = 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      station_number <= STATION_RESET;
      monitor_timer  <= TIMER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_STATION) begin
        station_number <= cfg_data[7:0];
      end else begin
        monitor_timer <= cfg_data;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      writing_frame <= 1'b0;
      word_device   <= 1'b0;
      points_left   <= 8'd0;
      held_nibble   <= 4'd0;
      nibble_held   <= 1'b0;
    end else if (req_fire) begin
      writing_frame <= writing_frame_next;
      word_device   <= word_device_next;
      points_left   <= points_left_next;
      held_nibble   <= held_nibble_next;
      nibble_held   <= nibble_held_next;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      batch_last <= 1'b0;
    end else if (req_fire) begin
      remaining  <= load_count;
      batch_last <= load_last;
    end else if (frm_fire) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

  // output buffer payload: load or shift down
  always_ff @(posedge clk) begin
    if (req_fire) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        byte_buf[i] <= load_bytes[i];
      end
    end else if (frm_fire) begin
      for (int i = 0; i < HDR_LEN - 1; i++) begin
        byte_buf[i] <= byte_buf[i+1];
      end
    end
  end

  // checks
  a_remaining_range : assert property (@(posedge clk) disable iff (rst)
    remaining <= CNT_W'(HDR_LEN))
    else $error("output buffer count out of range");

  a_nibble_in_bit_frame : assert property (@(posedge clk) disable iff (rst)
    nibble_held |-> (writing_frame && !word_device))
    else $error("held nibble outside a bit write frame");

  a_writing_has_points : assert property (@(posedge clk) disable iff (rst)
    writing_frame |-> (points_left != 8'd0))
    else $error("write frame pending with no points left");

  a_header_fills_buffer : assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.func == FUNC_HEADER)) |=> (remaining == CNT_W'(HDR_LEN)))
    else $error("header transaction did not load a full header");

endmodule
